### hdl/ppmc_pkg.sv
// Shared constants and types for the prefetch policy miss counter.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ppmc_pkg;

	// Default geometry, handed down from the top-level parameters
	localparam int LINE_SIZE_DEF    = 64;
	localparam int SET_COUNT_DEF    = 16;
	localparam int ADDRESS_BITS_DEF = 32;

	// Fixed field widths
	localparam int ADDR_PORT_W = 32;
	localparam int CNT_W       = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Per-transaction control into one cache
	typedef struct packed {
		logic fire;     // apply a demand lookup and fill
		logic pf_fire;  // also install the prefetch line (after the demand fill)
	} cache_ctl_t;

	// Per-transaction status out of one cache
	typedef struct packed {
		logic             miss;   // demand lookup missed
		logic [CNT_W-1:0] count;  // miss count including this lookup
	} cache_stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] val);
		sat_inc = (val == CNT_MAX) ? val : val + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

### hdl/ppmc_dm_cache.sv
// Direct-mapped tag store with valid bits, optional prefetch fill and a saturating
// miss counter. Depends on ppmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppmc_dm_cache #(
	parameter int SET_COUNT = 16,
	parameter int TAG_W     = 27
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire ppmc_pkg::cache_ctl_t ctl,
	input  wire [TAG_W-1:0]           dem_line,
	input  wire [TAG_W-1:0]           pf_line,
	output ppmc_pkg::cache_stat_t     stat
);
	import ppmc_pkg::*;

	localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;

	logic [TAG_W-1:0]     tag_q [SET_COUNT];
	logic [SET_COUNT-1:0] valid_q;
	logic [CNT_W-1:0]     count_q;

	logic [SET_W+TAG_W-1:0] dem_ext, pf_ext;
	logic [SET_W-1:0]       dem_set, pf_set;
	logic                   miss;
	logic [CNT_W-1:0]       count_nxt;

	// set = line mod SET_COUNT (power of two); widen first for tiny tags
	assign dem_ext = {{SET_W{1'b0}}, dem_line};
	assign pf_ext  = {{SET_W{1'b0}}, pf_line};
	assign dem_set = dem_ext[SET_W-1:0];
	assign pf_set  = pf_ext[SET_W-1:0];

	assign miss      = !(valid_q[dem_set] && (tag_q[dem_set] == dem_line));
	assign count_nxt = miss ? sat_inc(count_q) : count_q;

	assign stat.miss  = miss;
	assign stat.count = count_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (ctl.fire) begin
			count_q          <= count_nxt;
			valid_q[dem_set] <= 1'b1;
			if (ctl.pf_fire) begin
				valid_q[pf_set] <= 1'b1;
			end
		end
	end

	// prefetch fill lands after the demand fill, so it wins on a shared set
	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			tag_q[dem_set] <= dem_line;
			if (ctl.pf_fire) begin
				tag_q[pf_set] <= pf_line;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/ppmc_stride_pred.sv
// Stride predictor: keeps the last address and delta; proposes a prefetch line when
// two successive deltas match and the target is not negative. Depends on ppmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppmc_stride_pred #(
	parameter int AW     = 32,
	parameter int OFFS_W = 6,
	parameter int TAG_W  = 27
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              fire,
	input  wire [AW-1:0]     addr,
	output logic             pf_fire,
	output logic [TAG_W-1:0] pf_line
);
	import ppmc_pkg::*;

	logic [AW-1:0] prev_addr_q;
	logic [AW:0]   prev_delta_q;
	logic          hist_valid_q;

	logic [AW:0]   delta;
	logic [AW+1:0] target;

	assign delta  = {1'b0, addr} - {1'b0, prev_addr_q};
	// target = addr + delta, signed; top bit set means negative
	assign target = {2'b00, addr} + {delta[AW], delta};

	assign pf_fire = fire && hist_valid_q && (delta == prev_delta_q) && !target[AW+1];
	assign pf_line = target[AW:OFFS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_addr_q  <= '0;
			prev_delta_q <= '0;
			hist_valid_q <= 1'b0;
		end else if (fire) begin
			prev_addr_q <= addr;
			if (hist_valid_q) begin
				prev_delta_q <= delta;
			end
			hist_valid_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

### hdl/prefetch_policy_miss_counter.sv
// Top level of the prefetch policy miss counter: input register, three caches,
// stride predictor and result register. Depends on ppmc_pkg, ppmc_dm_cache, ppmc_stride_pred.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction carries one byte address, which is applied to three
// direct-mapped caches (no prefetch, next-line prefetch, stride prefetch) and
// produces exactly one result transaction with the three demand-miss flags, the
// stride-prediction flag and the three saturating miss counts including this
// access. The block takes one transaction per clock cycle while in_stall is low;
// the address lands in the input register, and the tag compare, fills and counter
// updates happen in the cycle it moves into the result register. The result
// register frees the input side, so a new address is accepted while a finished
// result waits, and in_stall rises only when both stages are full and out_stall
// is high. Valid bits, counters and stride history clear on reset, so the block
// is ready at once.
// LINE_SIZE and SET_COUNT must be powers of two; addresses use their low
// ADDRESS_BITS bits (capped at the 32-bit port).
module prefetch_policy_miss_counter #(
	parameter int LINE_SIZE    = ppmc_pkg::LINE_SIZE_DEF,
	parameter int SET_COUNT    = ppmc_pkg::SET_COUNT_DEF,
	parameter int ADDRESS_BITS = ppmc_pkg::ADDRESS_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [ppmc_pkg::ADDR_PORT_W-1:0]      address,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic                                  miss_plain,
	output logic                                  miss_next,
	output logic                                  miss_stride,
	output logic                                  stride_predicted,
	output logic [ppmc_pkg::CNT_W-1:0]            count_plain,
	output logic [ppmc_pkg::CNT_W-1:0]            count_next,
	output logic [ppmc_pkg::CNT_W-1:0]            count_stride
);
	import ppmc_pkg::*;

	localparam int AW     = (ADDRESS_BITS < ADDR_PORT_W) ? ADDRESS_BITS : ADDR_PORT_W;
	localparam int OFFS_W = $clog2(LINE_SIZE);
	// one extra bit: next-line and stride targets can run past the last demand line
	localparam int TAG_W  = AW - OFFS_W + 1;

	// Input stage
	logic          valid_s1;
	logic [AW-1:0] address_s1;

	// Result stage
	logic             valid_s2;
	logic             miss_plain_s2, miss_next_s2, miss_stride_s2, predicted_s2;
	logic [CNT_W-1:0] count_plain_s2, count_next_s2, count_stride_s2;

	logic out_free, fire, in_take;

	logic [TAG_W-1:0] dem_line, succ_line, stride_line;
	logic             stride_fire;
	cache_ctl_t       plain_ctl, next_ctl, stride_ctl;
	cache_stat_t      plain_stat, next_stat, stride_stat;

	// Advance the result stage when it is empty or being drained
	assign out_free = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	assign dem_line  = {1'b0, address_s1[AW-1:OFFS_W]};
	assign succ_line = dem_line + TAG_W'(1);

	// Demand lookups only act when the transaction advances
	assign plain_ctl.fire     = fire;
	assign plain_ctl.pf_fire  = 1'b0;
	assign next_ctl.fire      = fire;
	assign next_ctl.pf_fire   = next_stat.miss;  // next-line fill after a demand miss
	assign stride_ctl.fire    = fire;
	assign stride_ctl.pf_fire = stride_fire;

	ppmc_dm_cache #(.SET_COUNT(SET_COUNT), .TAG_W(TAG_W)) u_plain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (plain_ctl),
		.dem_line (dem_line),
		.pf_line  (dem_line),
		.stat     (plain_stat)
	);

	ppmc_dm_cache #(.SET_COUNT(SET_COUNT), .TAG_W(TAG_W)) u_next (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (next_ctl),
		.dem_line (dem_line),
		.pf_line  (succ_line),
		.stat     (next_stat)
	);

	ppmc_dm_cache #(.SET_COUNT(SET_COUNT), .TAG_W(TAG_W)) u_stride (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (stride_ctl),
		.dem_line (dem_line),
		.pf_line  (stride_line),
		.stat     (stride_stat)
	);

	// Stride history updates on the same edge as the caches
	ppmc_stride_pred #(.AW(AW), .OFFS_W(OFFS_W), .TAG_W(TAG_W)) u_stride_pred (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.addr    (address_s1),
		.pf_fire (stride_fire),
		.pf_line (stride_line)
	);

	// Hold the input register while the result stage is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			address_s1 <= address[AW-1:0];
		end
	end

	// Result register: load on advance, drop once taken downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			miss_plain_s2   <= plain_stat.miss;
			miss_next_s2    <= next_stat.miss;
			miss_stride_s2  <= stride_stat.miss;
			predicted_s2    <= stride_fire;
			count_plain_s2  <= plain_stat.count;
			count_next_s2   <= next_stat.count;
			count_stride_s2 <= stride_stat.count;
		end
	end

	assign out_valid        = valid_s2;
	assign miss_plain       = miss_plain_s2;
	assign miss_next        = miss_next_s2;
	assign miss_stride      = miss_stride_s2;
	assign stride_predicted = predicted_s2;
	assign count_plain      = count_plain_s2;
	assign count_next       = count_next_s2;
	assign count_stride     = count_stride_s2;

endmodule

`default_nettype wire

### hdl/ppmc_checker.sv
// Port-level checker for the prefetch policy miss counter, bound to the top level.
// Depends on ppmc_pkg and prefetch_policy_miss_counter.
`timescale 1ns / 1ps
`default_nettype none

module ppmc_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                out_valid,
	input wire                                out_stall,
	input wire                                miss_plain,
	input wire                                miss_next,
	input wire                                miss_stride,
	input wire [ppmc_pkg::CNT_W-1:0]          count_plain,
	input wire [ppmc_pkg::CNT_W-1:0]          count_next,
	input wire [ppmc_pkg::CNT_W-1:0]          count_stride
);
	import ppmc_pkg::*;

	logic             out_take;
	logic [CNT_W-1:0] last_plain_q, last_next_q, last_stride_q;

	assign out_take = out_valid && !out_stall;

	// Track the counts of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_plain_q  <= '0;
			last_next_q   <= '0;
			last_stride_q <= '0;
		end else if (out_take) begin
			last_plain_q  <= count_plain;
			last_next_q   <= count_next;
			last_stride_q <= count_stride;
		end
	end

	a_plain_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_take |-> count_plain == (miss_plain ? sat_inc(last_plain_q) : last_plain_q))
		else $error("plain miss count does not follow miss flag");

	a_next_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_take |-> count_next == (miss_next ? sat_inc(last_next_q) : last_next_q))
		else $error("next-line miss count does not follow miss flag");

	a_stride_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_take |-> count_stride == (miss_stride ? sat_inc(last_stride_q) : last_stride_q))
		else $error("stride miss count does not follow miss flag");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(count_plain)
			&& $stable(count_next) && $stable(count_stride)))
		else $error("stalled result changed");

endmodule

bind prefetch_policy_miss_counter ppmc_checker u_ppmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.miss_plain   (miss_plain),
	.miss_next    (miss_next),
	.miss_stride  (miss_stride),
	.count_plain  (count_plain),
	.count_next   (count_next),
	.count_stride (count_stride)
);

`default_nettype wire

### dv/ppmc_miss_check.sv
// Checker for the prefetch policy miss counter: watches both channels, predicts
// every result transaction and compares it field by field. Depends on ppmc_pkg.
`timescale 1ns / 1ps

module ppmc_miss_check (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	input  wire                             in_stall,
	input  wire [ppmc_pkg::ADDR_PORT_W-1:0] address,
	input  wire                             out_valid,
	input  wire                             out_stall,
	input  wire                             miss_plain,
	input  wire                             miss_next,
	input  wire                             miss_stride,
	input  wire                             stride_predicted,
	input  wire [ppmc_pkg::CNT_W-1:0]       count_plain,
	input  wire [ppmc_pkg::CNT_W-1:0]       count_next,
	input  wire [ppmc_pkg::CNT_W-1:0]       count_stride,
	output int                              failures,
	output int                              outstanding
);
	import ppmc_pkg::*;

	localparam int LINE_SHIFT = $clog2(LINE_SIZE_DEF);
	localparam int SET_BITS   = $clog2(SET_COUNT_DEF);
	localparam int LINE_W     = 28;

	typedef enum int {PLAIN = 0, LINE_AHEAD = 1, STRIDE = 2} policy_t;

	typedef struct {
		logic             miss_plain;
		logic             miss_next;
		logic             miss_stride;
		logic             stride_predicted;
		logic [CNT_W-1:0] count_plain;
		logic [CNT_W-1:0] count_next;
		logic [CNT_W-1:0] count_stride;
	} miss_report_t;

	logic [LINE_W-1:0]      line_tag   [3][SET_COUNT_DEF];
	logic                   line_valid [3][SET_COUNT_DEF];
	logic [CNT_W-1:0]       miss_total [3];
	logic [ADDR_PORT_W-1:0] last_address;
	logic signed [32:0]     last_delta;
	logic                   have_history;
	miss_report_t           reports_due [$];
	miss_report_t           oldest;
	int                     fail_count;

	// Install a line in one cache; return whether it was already resident.
	function automatic logic install_line(policy_t p, logic [LINE_W-1:0] line);
		logic [SET_BITS-1:0] set_idx;
		logic                hit;
		set_idx = line[SET_BITS-1:0];
		hit = line_valid[p][set_idx] && line_tag[p][set_idx] == line;
		line_valid[p][set_idx] = 1'b1;
		line_tag[p][set_idx] = line;
		return hit;
	endfunction

	function automatic logic demand_miss(policy_t p, logic [LINE_W-1:0] line);
		if (install_line(p, line))
			return 1'b0;
		if (miss_total[p] != '1)
			miss_total[p] = miss_total[p] + 1'b1;
		return 1'b1;
	endfunction

	function automatic miss_report_t predict_access(logic [ADDR_PORT_W-1:0] addr);
		miss_report_t      r;
		logic [LINE_W-1:0] line;
		longint            delta;
		longint            target;
		line = LINE_W'(addr >> LINE_SHIFT);
		r.miss_plain = demand_miss(PLAIN, line);
		r.miss_next = demand_miss(LINE_AHEAD, line);
		if (r.miss_next)
			void'(install_line(LINE_AHEAD, line + 1'b1));
		r.miss_stride = demand_miss(STRIDE, line);
		r.stride_predicted = 1'b0;
		if (have_history) begin
			delta = longint'(addr) - longint'(last_address);
			if (delta == longint'(last_delta)) begin
				target = longint'(addr) + delta;
				// a prefetch below address zero is dropped
				if (target >= 0) begin
					void'(install_line(STRIDE, LINE_W'(target >> LINE_SHIFT)));
					r.stride_predicted = 1'b1;
				end
			end
			last_delta = 33'(delta);
		end else begin
			have_history = 1'b1;
		end
		last_address = addr;
		r.count_plain = miss_total[PLAIN];
		r.count_next = miss_total[LINE_AHEAD];
		r.count_stride = miss_total[STRIDE];
		return r;
	endfunction

	function automatic void compare_field(string name, logic [CNT_W-1:0] want,
			logic [CNT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < 3; p++) begin
				for (int s = 0; s < SET_COUNT_DEF; s++) begin
					line_tag[p][s] = '0;
					line_valid[p][s] = 1'b0;
				end
				miss_total[p] = '0;
			end
			last_address = '0;
			last_delta = '0;
			have_history = 1'b0;
			reports_due.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					$display("%0t: result with no access pending, got counts %0h %0h %0h",
						$time, count_plain, count_next, count_stride);
					fail_count++;
				end else begin
					oldest = reports_due.pop_front();
					compare_field("miss_plain", oldest.miss_plain, miss_plain);
					compare_field("miss_next", oldest.miss_next, miss_next);
					compare_field("miss_stride", oldest.miss_stride, miss_stride);
					compare_field("stride_predicted", oldest.stride_predicted,
						stride_predicted);
					compare_field("count_plain", oldest.count_plain, count_plain);
					compare_field("count_next", oldest.count_next, count_next);
					compare_field("count_stride", oldest.count_stride, count_stride);
				end
			end
			if (in_valid && !in_stall)
				reports_due.push_back(predict_access(address));
		end
		failures <= fail_count;
		outstanding <= reports_due.size();
	end

endmodule

### dv/prefetch_policy_miss_counter_test.sv
// Top of the prefetch policy miss counter testbench: clock, reset, address stimulus,
// random back-pressure and the verdict. Depends on ppmc_pkg, ppmc_miss_check and the block.
`timescale 1ns / 1ps

module prefetch_policy_miss_counter_test;
	import ppmc_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 13;
	localparam int DRAIN_CYCLES = 8;
	localparam int SAME_SET_SPAN = SET_COUNT_DEF * LINE_SIZE_DEF;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic [ADDR_PORT_W-1:0] address = '0;
	logic                   out_stall = 1'b0;
	wire                    in_stall;
	wire                    out_valid;
	wire                    miss_plain;
	wire                    miss_next;
	wire                    miss_stride;
	wire                    stride_predicted;
	wire [CNT_W-1:0]        count_plain;
	wire [CNT_W-1:0]        count_next;
	wire [CNT_W-1:0]        count_stride;
	int                     failures;
	int                     outstanding;
	int                     cycles = 0;
	int                     sent = 0;
	// While set, neither side idles: gives a stretch at full rate.
	logic                   steady = 1'b0;

	prefetch_policy_miss_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.miss_plain(miss_plain),
		.miss_next(miss_next),
		.miss_stride(miss_stride),
		.stride_predicted(stride_predicted),
		.count_plain(count_plain),
		.count_next(count_next),
		.count_stride(count_stride)
	);

	ppmc_miss_check miss_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.miss_plain(miss_plain),
		.miss_next(miss_next),
		.miss_stride(miss_stride),
		.stride_predicted(stride_predicted),
		.count_plain(count_plain),
		.count_next(count_next),
		.count_stride(count_stride),
		.failures(failures),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	// Receiver side: stall at random, never during the steady stretch.
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	// Watchdog: give up well past the slowest legal run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("prefetch_policy_miss_counter regression: fail");
			$finish;
		end
	end

	// Offer one address and hold it until the block takes the transaction.
	// Idle cycles go in front of it at random outside the steady stretch.
	task automatic send_address(input logic [ADDR_PORT_W-1:0] addr);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		address <= addr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		steady <= (sent >= 700 && sent < 1000);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Constant-stride run: the shape the stride cache is built to catch.
	task automatic send_stream(input logic [ADDR_PORT_W-1:0] base, input int stride,
			input int len);
		for (int i = 0; i < len; i++)
			send_address(base + ADDR_PORT_W'(i * stride));
	endtask

	function automatic int pick_stride();
		case ($urandom_range(3))
			0: return int'($urandom_range(512)) - 256;
			1: return (int'($urandom_range(32)) - 16) * LINE_SIZE_DEF;
			// demand and prefetch land in the same set
			2: return $urandom_range(1) ? SAME_SET_SPAN : -SAME_SET_SPAN;
			default: return int'($urandom);
		endcase
	endfunction

	function automatic logic [ADDR_PORT_W-1:0] pick_base();
		case ($urandom_range(3))
			// near zero, so descending runs aim below address zero
			0: return ADDR_PORT_W'($urandom_range(4096));
			1: return 32'hFFFF_FFFF - ADDR_PORT_W'($urandom_range(4096));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [ADDR_PORT_W-1:0] base;
		logic [ADDR_PORT_W-1:0] region;
		logic [ADDR_PORT_W-1:0] addr;
		int                     stride;
		int                     len;
		int                     glitch;
		int                     pick;
		bit                     drained_mid;

		drained_mid = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// First access forms no delta; the repeat compares a zero delta with the
		// reset delta and so predicts its own line.
		send_address(32'h0000_0000);
		send_address(32'h0000_0000);
		// line 1 was filled by the next-line prefetch after the first miss
		send_address(32'h0000_0040);
		// address extremes and alternating bit patterns
		send_address(32'hFFFF_FFFF);
		send_address(32'hFFFF_FFC0);
		send_address(32'hAAAA_AAAA);
		send_address(32'h5555_5555);
		// descending run: target exactly zero is kept, the next one goes negative
		send_address(32'd300);
		send_address(32'd200);
		send_address(32'd100);
		send_address(32'd0);
		// stride of one set span: the prefetch overwrites the demand fill,
		// so the revisit misses only in the stride cache
		send_address(32'h0000_1000);
		send_address(32'h0000_1400);
		send_address(32'h0000_1800);
		send_address(32'h0000_1800);
		// ascending run at the top: the prefetch target lies above 32 bits
		send_address(32'hFFFF_FD00);
		send_address(32'hFFFF_FE00);
		send_address(32'hFFFF_FF00);
		send_address(32'hFFFF_FFFF);

		// Let the pipeline empty once before the random part.
		wait_for_drain();

		while (sent < RANDOM_ITEMS + 19) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_stream(pick_base(), pick_stride(), $urandom_range(12, 3));
			end else if (pick < 75) begin
				// Working set inside 2 KB: plenty of hits and conflict misses.
				// Half the time reuse one of a few low regions across bursts.
				region = $urandom_range(1) ? ($urandom & 32'hFFFF_F000)
					: (ADDR_PORT_W'($urandom_range(3)) << 12);
				len = $urandom_range(16, 4);
				for (int i = 0; i < len; i++)
					send_address(region + ADDR_PORT_W'($urandom_range(2047)));
			end else if (pick < 90) begin
				len = $urandom_range(4, 1);
				for (int i = 0; i < len; i++)
					send_address($urandom);
			end else begin
				// Broken run: one step replaced by a random address or a repeat.
				base = pick_base();
				stride = pick_stride();
				len = $urandom_range(8, 4);
				glitch = $urandom_range(len - 1, 1);
				addr = base;
				for (int i = 0; i < len; i++) begin
					if (i == glitch)
						addr = $urandom_range(1) ? $urandom : addr;
					else
						addr = base + ADDR_PORT_W'(i * stride);
					send_address(addr);
				end
			end
			if (!drained_mid && sent >= 1200) begin
				wait_for_drain();
				drained_mid = 1'b1;
			end
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("prefetch_policy_miss_counter regression: pass");
		else
			$display("prefetch_policy_miss_counter regression: fail");
		$finish;
	end

endmodule
